[design/psbb_pkg.sv]
// ----------------------------------------------------------------------------
// psbb_pkg
// shared types, widths and helpers for the point set bounding box block
// ----------------------------------------------------------------------------
`default_nettype none

package psbb_pkg;

    // coordinate width, signed q16.16
    localparam int CW       = 32;
    localparam int AXES     = 3;
    localparam int TOL_W    = 16;
    localparam int TEN_W    = TOL_W + 4;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef logic signed [CW-1:0] t_coord;
    typedef logic        [CW-1:0] t_ext;

    // one incoming point
    typedef struct packed {
        logic                 last;
        t_coord [AXES-1:0]    coord;
    } t_point;

    // corners of a finished set
    typedef struct packed {
        t_coord [AXES-1:0]    hi;
        t_coord [AXES-1:0]    lo;
    } t_box;

    // result word, centres in the low bits, extents above
    typedef struct packed {
        t_ext   [AXES-1:0]    ext;
        t_coord [AXES-1:0]    ctr;
    } t_result;

    localparam int IN_DATA_W  = AXES * CW;
    localparam int OUT_DATA_W = $bits(t_result);

    // ten times the tolerance as 8x + 2x
    function automatic logic [TEN_W-1:0] ten_times(input logic [TOL_W-1:0] tol);
        logic [TEN_W-1:0] wide;
        wide      = {4'b0000, tol};
        ten_times = (wide << 3) + (wide << 1);
    endfunction

endpackage

`default_nettype wire

[design/psbb_accum.sv]
// ----------------------------------------------------------------------------
// psbb_accum
// input register and running per-axis minimum and maximum of the current set
// ----------------------------------------------------------------------------
`default_nettype none

module psbb_accum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire psbb_pkg::t_point i_point,
    output logic                  o_box_valid,
    input  wire logic             i_box_ready,
    output psbb_pkg::t_box        o_box
);
    import psbb_pkg::*;

    logic                r_in_valid;
    t_point              r_in;
    logic                r_started;
    t_coord [AXES-1:0]   r_lo;
    t_coord [AXES-1:0]   r_hi;
    logic                r_box_valid;
    t_box                r_box;

    t_coord [AXES-1:0]   n_lo;
    t_coord [AXES-1:0]   n_hi;
    logic                box_free;
    logic                in_move;

    // new corners, seeded by the first point of a set
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (!r_started) begin
                n_lo[a] = r_in.coord[a];
                n_hi[a] = r_in.coord[a];
            end else begin
                n_lo[a] = ($signed(r_in.coord[a]) < $signed(r_lo[a])) ? r_in.coord[a] : r_lo[a];
                n_hi[a] = ($signed(r_in.coord[a]) > $signed(r_hi[a])) ? r_in.coord[a] : r_hi[a];
            end
        end
    end

    // only a last point can wait, and only for the box register
    assign box_free = !r_box_valid || i_box_ready;
    assign in_move  = r_in_valid && (!r_in.last || box_free);
    assign o_ready  = !r_in_valid || in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_started   <= 1'b0;
            r_box_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (in_move) begin
                r_started <= !r_in.last;
            end
            if (in_move && r_in.last) begin
                r_box_valid <= 1'b1;
            end else if (i_box_ready) begin
                r_box_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_point;
        end
        if (in_move) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (in_move && r_in.last) begin
            r_box.lo <= n_lo;
            r_box.hi <= n_hi;
        end
    end

    assign o_box_valid = r_box_valid;
    assign o_box       = r_box;

endmodule

`default_nettype wire

[design/psbb_finish.sv]
// ----------------------------------------------------------------------------
// psbb_finish
// centre and half extent of a finished box, with tolerance clamp
// ----------------------------------------------------------------------------
`default_nettype none

module psbb_finish (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_box_valid,
    output logic                             o_box_ready,
    input  wire psbb_pkg::t_box              i_box,
    input  wire logic [psbb_pkg::TOL_W-1:0]  i_tol,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output psbb_pkg::t_result                o_result
);
    import psbb_pkg::*;

    logic                r_valid;
    t_result             r_result;
    t_result             n_result;

    logic [CW:0]         sum      [AXES];
    logic [CW:0]         ctr_full [AXES];
    logic [CW:0]         ext_full [AXES];
    logic [CW-1:0]       tol_wide;
    logic [CW-1:0]       ten_wide;

    assign tol_wide = {{(CW-TOL_W){1'b0}}, i_tol};
    assign ten_wide = {{(CW-TEN_W){1'b0}}, ten_times(i_tol)};

    // sum at one extra bit, arithmetic shift gives the floored half
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            sum[a]      = {i_box.hi[a][CW-1], i_box.hi[a]} + {i_box.lo[a][CW-1], i_box.lo[a]};
            ctr_full[a] = {sum[a][CW], sum[a][CW:1]};
            ext_full[a] = {i_box.hi[a][CW-1], i_box.hi[a]} - ctr_full[a];
            n_result.ctr[a] = ctr_full[a][CW-1:0];
            n_result.ext[a] = (ext_full[a][CW-1:0] <= tol_wide) ? ten_wide
                                                                : ext_full[a][CW-1:0];
        end
    end

    assign o_box_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_box_ready) begin
            r_valid <= i_box_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_box_valid && o_box_ready) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[design/point_set_bounding_box.sv]
// ----------------------------------------------------------------------------
// point_set_bounding_box
// axis-aligned bounding box of a stream of 3d points in signed q16.16
// ----------------------------------------------------------------------------
// Points arrive one per word on the slave stream; the first point of a set
// seeds the per-axis minimum and maximum and later points widen them. The
// point marked with tlast takes part in the box and closes the set: one
// result word follows on the master stream with the centre, floor of
// (max + min) / 2, and the half extent, max minus centre, on each axis. A
// half extent at or below the tolerance register is replaced by ten times
// the tolerance. The block takes one point every cycle; the only thing that
// can hold the input back is a full result path (box register and output
// register) while the master side stalls. A last point passes from the input
// register into the corner and box registers, and its result from there into
// the output register behind the centre/extent adder and clamp. The tolerance
// register resets to 1 and should only be written while no set is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module point_set_bounding_box (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream: tdata = point_x, point_y, point_z; tlast = last_point
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [psbb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    // master stream: tdata = center_x, center_y, center_z,
    //                        extent_x, extent_y, extent_z
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [psbb_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // extent_tolerance register
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [psbb_pkg::TOL_W-1:0]         i_cfg_wr_data
);
    import psbb_pkg::*;

    logic [TOL_W-1:0]   r_tol;
    t_point             point;
    logic               box_valid;
    logic               box_ready;
    t_box               box;
    t_result            result;

    // tolerance register, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // coordinates packed x lowest, last flag from tlast
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            point.coord[a] = s_axis_tdata[a*CW +: CW];
        end
        point.last = s_axis_tlast;
    end

    // running min/max and closed-set capture
    psbb_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_point     (point),
        .o_box_valid (box_valid),
        .i_box_ready (box_ready),
        .o_box       (box)
    );

    // centre, extent and tolerance clamp into the output register
    psbb_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_valid (box_valid),
        .o_box_ready (box_ready),
        .i_box       (box),
        .i_tol       (r_tol),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = result;

endmodule

`default_nettype wire

[design/psbb_checker.sv]
// ----------------------------------------------------------------------------
// psbb_checker
// port-level checks for the point set bounding box, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module psbb_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [psbb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [psbb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [psbb_pkg::TOL_W-1:0]         i_cfg_wr_data
);
    import psbb_pkg::*;

    logic [TOL_W-1:0]   r_tol;
    logic [2:0]         r_pending;
    logic               last_in;
    logic               word_out;
    t_result            res;
    logic [CW-1:0]      tol_wide;
    logic [CW-1:0]      ten_wide;
    logic               ext_ok;
    logic               ext_bounded;

    assign last_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign word_out = m_axis_tvalid && m_axis_tready;
    assign res      = m_axis_tdata;
    assign tol_wide = {{(CW-TOL_W){1'b0}}, r_tol};
    assign ten_wide = {{(CW-TEN_W){1'b0}}, ten_times(r_tol)};

    // shadow of the tolerance register and count of closed sets not yet out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= TOL_RESET;
            r_pending <= 3'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            r_pending <= r_pending + {2'b00, last_in} - {2'b00, word_out};
        end
    end

    always_comb begin
        ext_ok      = 1'b1;
        ext_bounded = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            if (!(res.ext[a] > tol_wide || res.ext[a] == ten_wide)) begin
                ext_ok = 1'b0;
            end
            if (res.ext[a][CW-1] && (res.ext[a][CW-2:0] != '0)) begin
                ext_bounded = 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != 3'd0) && (r_pending <= 3'd3))
        else $error("result without a closed set, or too many sets in flight");

    a_ext_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ext_ok)
        else $error("extent at or below tolerance not replaced");

    a_ext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ext_bounded)
        else $error("extent beyond half the coordinate range");

endmodule

bind point_set_bounding_box psbb_checker u_psbb_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the point set bounding box block
// ----------------------------------------------------------------------------
// Points are streamed into the slave side from a queue. A behavioural model of
// the corner tracking and the centre/extent step predicts one box per
// set, and every word leaving the master side is compared with it field by
// field. The run steps through several tolerance settings. It opens with
// hand-picked sets: single points, full-range corners, extents right at the
// tolerance and zero tolerance. Random sets follow: wide, clustered and
// corner values. Both sides idle in short random bursts. One phase stalls the
// receiver long enough to back the block up to its input, and the final
// phase runs without gaps.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psbb_pkg::*;

    localparam t_coord COORD_MAX = 32'sh7fff_ffff;
    localparam t_coord COORD_MIN = 32'sh8000_0000;

    // how the points of one random set are spread
    typedef enum int {
        SPREAD_WIDE,
        SPREAD_CLUSTER,
        SPREAD_CORNER,
        SPREAD_MIXED
    } spread_e;

    // dut connections, all inputs known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // point_x, point_y, point_z
    logic                  s_axis_tlast  = 1'b0; // last_point
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // center_x, center_y, center_z,
                                                // extent_x, extent_y, extent_z
    logic                  i_cfg_wr_en   = 1'b0;
    logic [TOL_W-1:0]      i_cfg_wr_data = '0;

    point_set_bounding_box u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    // points waiting to go out and boxes waiting to come back
    t_point  point_q[$];
    t_result box_q[$];

    // model state: tolerance and the corners of the open set
    logic [TOL_W-1:0] tol_model = TOL_RESET;
    longint           low_corner[3];
    longint           high_corner[3];
    bit               set_open = 1'b0;

    int  points_queued = 0;
    int  points_taken  = 0;
    int  boxes_checked = 0;
    int  clamped_exts  = 0;
    int  tol_settings  = 1;
    int  fail_count    = 0;
    bit  point_taken_now = 1'b0;

    // idling control, written only by the sequencing block
    int  idle_pct   = 0;
    bit  hold_armed = 1'b0;

    string axis_name[3] = '{"x", "y", "z"};

    // ------------------------------------------------------------------
    // prediction: fold one accepted point into the box, emit on last
    // ------------------------------------------------------------------
    task automatic fold_point(input t_point p);
        longint  c;
        longint  ctr;
        longint  ext;
        t_result r;
        for (int a = 0; a < AXES; a++) begin
            c = longint'(p.coord[a]);
            if (!set_open) begin
                low_corner[a]  = c;
                high_corner[a] = c;
            end else begin
                if (c > high_corner[a]) high_corner[a] = c;
                if (c < low_corner[a])  low_corner[a]  = c;
            end
        end
        set_open = 1'b1;
        if (p.last) begin
            for (int a = 0; a < AXES; a++) begin
                // arithmetic shift of the 64-bit sum floors towards minus infinity
                ctr = (high_corner[a] + low_corner[a]) >>> 1;
                ext = high_corner[a] - ctr;
                if (ext <= longint'(tol_model)) begin
                    ext = longint'(tol_model) * 10;
                    clamped_exts++;
                end
                r.ctr[a] = ctr[CW-1:0];
                r.ext[a] = ext[CW-1:0];
            end
            box_q.push_back(r);
            set_open = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        fail_count++;
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_point  p;
        point_taken_now = s_axis_tvalid && s_axis_tready;
        if (point_taken_now) begin
            p.coord = s_axis_tdata;
            p.last  = s_axis_tlast;
            fold_point(p);
            points_taken++;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (box_q.size() == 0) begin
                report_mismatch("unexpected result word", got.ctr[0], '0);
            end else begin
                want = box_q.pop_front();
                boxes_checked++;
                for (int a = 0; a < AXES; a++) begin
                    if (got.ctr[a] !== want.ctr[a])
                        report_mismatch({"center_", axis_name[a]}, got.ctr[a], want.ctr[a]);
                    if (got.ext[a] !== want.ext[a])
                        report_mismatch({"extent_", axis_name[a]}, got.ext[a], want.ext[a]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: presents the next queued point, with random gaps
    // ------------------------------------------------------------------
    int tx_gap = 0;

    always @(negedge i_clk) begin
        t_point p;
        if (!s_axis_tvalid || point_taken_now) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (point_q.size() > 0) begin
                p = point_q.pop_front();
                s_axis_tdata  <= p.coord;
                s_axis_tlast  <= p.last;
                s_axis_tvalid <= 1'b1;
                if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                    tx_gap = $urandom_range(1, 5);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus one long hold when armed
    // ------------------------------------------------------------------
    int rx_gap  = 0;
    int rx_hold = 0;
    bit hold_used = 1'b0;

    always @(negedge i_clk) begin
        if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            rx_hold   = 300;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                rx_gap = $urandom_range(1, 5);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_point(input t_coord x, input t_coord y, input t_coord z,
                              input bit last);
        t_point p;
        p.coord[0] = x;
        p.coord[1] = y;
        p.coord[2] = z;
        p.last     = last;
        point_q.push_back(p);
        points_queued++;
    endtask

    // wait for every point to be taken and every box to come back, then
    // give the pipeline time to settle (three stages deep)
    task automatic wait_idle();
        do @(negedge i_clk);
        while (points_taken != points_queued || box_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= tol;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tol_model = tol;
        tol_settings++;
        @(posedge i_clk);
    endtask

    function automatic t_coord pick_coord(input spread_e mode, input t_coord base,
                                          input int unsigned span);
        spread_e m;
        m = mode;
        if (m == SPREAD_MIXED)
            m = spread_e'($urandom_range(2));
        case (m)
            SPREAD_CLUSTER: begin
                // keeps the extent around the tolerance so the clamp gets hit
                return base + t_coord'($urandom_range(span));
            end
            SPREAD_CORNER: begin
                case ($urandom_range(4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return t_coord'(0);
                    3: return t_coord'(-1);
                    default: return t_coord'(1);
                endcase
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    // random sets, mostly short with the odd longer one
    task automatic queue_sets(input int n_points, input int short_max, input int long_max);
        int          queued;
        int          len;
        int unsigned span;
        spread_e     mode;
        t_coord      base[3];
        t_coord      c[3];
        queued = 0;
        while (queued < n_points) begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(short_max + 1, long_max);
            else
                len = $urandom_range(1, short_max);
            mode = spread_e'($urandom_range(3));
            span = 2 * int'(tol_model) + 3;
            for (int a = 0; a < AXES; a++)
                base[a] = t_coord'($urandom);
            for (int i = 0; i < len; i++) begin
                for (int a = 0; a < AXES; a++)
                    c[a] = pick_coord(mode, base[a], span);
                send_point(c[0], c[1], c[2], i == len - 1);
            end
            queued += len;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial begin
        logic [TOL_W-1:0] rnd_tol;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets under the reset tolerance of one
        idle_pct = 20;
        send_point(0, 0, 0, 1'b1);                          // single point at origin
        send_point(COORD_MAX, COORD_MIN, -1, 1'b1);         // single point, extremes
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);  // full range on every axis
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MAX, 0, COORD_MIN, 1'b0);          // repeated point, zero extent
        send_point(COORD_MAX, 0, COORD_MIN, 1'b1);
        send_point(0, 0, -3, 1'b0);                         // extent equal to and above tol
        send_point(2, 3, 0, 1'b1);
        send_point(5, -5, 0, 1'b0);                         // widening both ways
        send_point(-7, 9, 1, 1'b0);
        send_point(3, 3, -100, 1'b1);
        wait_idle();

        // zero tolerance: only a zero extent is replaced, and by zero
        set_tolerance('0);
        send_point(7, 7, 7, 1'b1);
        send_point(0, -1, 100, 1'b0);
        send_point(1, 0, 102, 1'b1);
        wait_idle();

        // largest tolerance, extents just at and just past it
        set_tolerance('1);
        send_point(0, COORD_MIN, -131070, 1'b0);
        send_point(131070, COORD_MIN + 131072, 0, 1'b1);
        send_point(COORD_MAX - 131070, 0, 5, 1'b0);
        send_point(COORD_MAX, 131073, 5, 1'b1);
        wait_idle();

        // random phases across a range of tolerances
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: rnd_tol = TOL_RESET;
                1: rnd_tol = '0;
                3: rnd_tol = '1;
                default: rnd_tol = TOL_W'($urandom);
            endcase
            set_tolerance(rnd_tol);
            idle_pct = (ph == 2) ? 0 : $urandom_range(10, 40);
            queue_sets(250, 6, 40);
            wait_idle();
        end

        // long receiver hold with short sets: the block backs up to its input
        set_tolerance(TOL_W'($urandom_range(1, 200)));
        idle_pct   = 0;
        hold_armed = 1'b1;
        queue_sets(150, 2, 3);
        wait_idle();

        // closing stretch with no idling on either side
        set_tolerance(TOL_W'($urandom));
        idle_pct = 0;
        queue_sets(100, 6, 20);
        wait_idle();

        repeat (10) @(posedge i_clk);
        $display("covered %0d points in %0d boxes over %0d tolerance settings",
                 points_taken, boxes_checked, tol_settings);
        $display("%0d extents clamped, one long output stall, %0d mismatches",
                 clamped_exts, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout waiting for the block to drain");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
